FILE: design/length_prefixed_ring_message_queue_unit_assert.svh
// assertion macros used by the checker file
`ifndef LENGTH_PREFIXED_RING_MESSAGE_QUEUE_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_RING_MESSAGE_QUEUE_UNIT_ASSERT_SVH

// concurrent check, switched off while reset is high
`define LPRQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds across reset
`define LPRQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lprq_pkg.sv
package lprq_pkg;

  localparam int STORE_BYTES_DEF   = 2048;
  localparam int SEGMENT_BYTES_DEF = 512;

  localparam int RING_SIZE_W = 12;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;
  localparam int STATUS_W    = 3;

  localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 12'd2048;

  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] KEPT_MAX = 8'hFF;

  localparam logic KIND_PUSH = 1'b0;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_COLLISION = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_CLEARED   = 3'd4
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_RING_SIZE      = 1'b0,
    REG_ESCAPE_REMOVAL = 1'b1
  } cfg_reg_t;

endpackage

FILE: design/length_prefixed_ring_message_queue_unit.sv
// one item in flight: start is taken while busy is low, and results are registered
// pop: a store read, or a length read and then a byte read when a message opens
// push: a store write, plus the length slot write on a last byte; a first byte adds the
//   space check; a length crossing a segment adds wrap steps that subtract the ring length
// empty pop, stray push byte: from idle; done lasts one cycle, the next start is taken then
// rst clears pointers and counters, ring_size 2048, escape removal on; store undefined
module length_prefixed_ring_message_queue_unit
  import lprq_pkg::*;
#(
  parameter int STORE_BYTES   = STORE_BYTES_DEF,
  parameter int SEGMENT_BYTES = SEGMENT_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   kind,
  input  logic [7:0]             data_in,
  input  logic [7:0]             msg_length,
  input  logic                   first_byte,
  input  logic                   last_byte,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   done,
  output logic [STATUS_W-1:0]    status,
  output logic [7:0]             data_out,
  output logic                   byte_valid,
  output logic                   message_end,
  output logic [7:0]             popped_length
);

  // pointer width, and one bit more for lengths and sums that can reach the store size
  localparam int PW        = $clog2(STORE_BYTES);
  localparam int RW        = PW + 1;
  localparam int SEG_SHIFT = $clog2(SEGMENT_BYTES);
  localparam logic [RW-1:0] SEG_MASK = RW'(SEGMENT_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRAP,   // reduce the end of a new message into the ring
    S_SPACE,  // free span and length slot checks
    S_BYTE,   // stage one payload byte
    S_COMMIT, // write the length slot and publish the message
    S_PLEN,   // length byte arrives from the store
    S_PDATA   // payload byte arrives from the store
  } state_t;

  state_t state;

  // queue pointers and push/pop progress
  logic [PW-1:0]          rp;
  logic [PW-1:0]          wp;
  logic [PW-1:0]          sp;
  logic [7:0]             kept;
  logic                   esc_pend;
  logic                   push_open;
  logic [7:0]             pop_rem;

  // configuration
  logic [RING_SIZE_W-1:0] ring_size;
  logic                   esc_rm;

  // item held while it is worked on
  logic [7:0]             it_data;
  logic [7:0]             it_len;
  logic                   it_last;
  logic [RW-1:0]          aux;

  // store port
  logic                   ram_we;
  logic [PW-1:0]          ram_waddr;
  logic [7:0]             ram_wdata;
  logic [PW-1:0]          ram_raddr;
  logic [7:0]             ram_rdata;

  logic [RW-1:0]          rlen;
  logic [PW-1:0]          wp_next1;
  logic [PW-1:0]          sp_next1;
  logic [PW-1:0]          rp_next1;
  logic [RW-1:0]          aux_first;
  logic [RW-1:0]          free_span;
  logic                   space_ok;
  logic                   byte_esc;
  logic                   byte_full;
  logic [7:0]             byte_value;

  // advance with wrap at the ring length
  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p,
                                               input logic [RW-1:0] len);
    logic [RW-1:0] q;
    q = RW'(p) + RW'(1);
    return (q >= len) ? '0 : q[PW-1:0];
  endfunction

  function automatic logic [RW-1:0] seg_of(input logic [RW-1:0] p);
    return p >> SEG_SHIFT;
  endfunction

  // p sits on the first byte of the segment holding r
  function automatic logic seg_start_in(input logic [PW-1:0] p, input logic [PW-1:0] r);
    return ((RW'(p) & SEG_MASK) == '0) && (seg_of(RW'(p)) == seg_of(RW'(r)));
  endfunction

  // ring length clamped to at least 2 and at most what the store holds
  always_comb begin
    if (ring_size < 12'd2) begin
      rlen = RW'(2);
    end else if (ring_size > STORE_BYTES) begin
      rlen = RW'(STORE_BYTES);
    end else begin
      rlen = RW'(ring_size);
    end
  end

  assign wp_next1  = ring_next(wp, rlen);
  assign sp_next1  = ring_next(sp, rlen);
  assign rp_next1  = ring_next(rp, rlen);
  assign aux_first = RW'(wp) + RW'(msg_length);

  // free span must exceed the raw length plus its length slot
  assign free_span = (wp >= rp) ? (rlen - (RW'(wp) - RW'(rp))) : (RW'(rp) - RW'(wp));
  assign space_ok  = free_span > (RW'(it_len) + RW'(1));

  // with removal on, an escape byte is dropped and flags the next kept byte
  assign byte_esc   = esc_rm && (it_data == ESC_BYTE);
  assign byte_full  = (sp_next1 == rp) || (kept == KEPT_MAX);
  assign byte_value = esc_pend ? (it_data ^ ESC_XOR) : it_data;

  // writes only in push states and reads only from idle or pop states, one item at a time,
  // so a read never meets a write to the same entry in flight
  always_comb begin
    ram_we    = ((state == S_BYTE) && !byte_esc && !byte_full) || (state == S_COMMIT);
    ram_waddr = (state == S_COMMIT) ? wp : sp;
    ram_wdata = (state == S_COMMIT) ? kept : byte_value;
    ram_raddr = (state == S_PLEN) ? rp_next1 : rp;
  end

  lprq_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rp        <= '0;
      wp        <= '0;
      sp        <= '0;
      kept      <= '0;
      esc_pend  <= 1'b0;
      push_open <= 1'b0;
      pop_rem   <= '0;
      ring_size <= RING_SIZE_RESET;
      esc_rm    <= 1'b1;
      done      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_RING_SIZE:      ring_size <= cfg_data[RING_SIZE_W-1:0];
          REG_ESCAPE_REMOVAL: esc_rm    <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            // result fields default to no byte
            data_out      <= '0;
            byte_valid    <= 1'b0;
            popped_length <= '0;
            it_data       <= data_in;
            it_len        <= msg_length;
            it_last       <= last_byte;
            if (kind == KIND_PUSH) begin
              status      <= ST_OK;
              message_end <= 1'b0;
              if (first_byte) begin
                // a new message abandons any open one
                push_open <= 1'b0;
                kept      <= '0;
                esc_pend  <= 1'b0;
                aux       <= aux_first;
                done      <= 1'b0;
                state     <= (seg_of(aux_first) != seg_of(RW'(wp))) ? S_WRAP : S_SPACE;
              end else if (push_open) begin
                done  <= 1'b0;
                state <= S_BYTE;
              end else begin
                // stray or discarded byte
                done <= 1'b1;
              end
            end else begin
              // nothing left: an open message ends here without a byte
              status      <= (rp == wp) ? ST_EMPTY : ST_OK;
              message_end <= (rp == wp) && (pop_rem != '0);
              done        <= (rp == wp);
              if (rp == wp) begin
                pop_rem <= '0;
              end else if (pop_rem == '0) begin
                state <= S_PLEN;
              end else begin
                state <= S_PDATA;
              end
            end
          end else begin
            done <= 1'b0;
          end
        end

        S_WRAP: begin
          if (aux >= rlen) begin
            aux  <= aux - rlen;
            done <= 1'b0;
          end else if (seg_of(aux) == seg_of(RW'(rp))) begin
            status <= ST_COLLISION;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            done  <= 1'b0;
            state <= S_SPACE;
          end
        end

        S_SPACE: begin
          if ((wp_next1 == rp) || !space_ok) begin
            status <= ST_NO_SPACE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            // staging starts behind the length slot
            sp <= wp_next1;
            if (seg_start_in(wp_next1, rp)) begin
              status <= ST_COLLISION;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              push_open <= 1'b1;
              done      <= 1'b0;
              state     <= S_BYTE;
            end
          end
        end

        S_BYTE: begin
          if (byte_esc) begin
            esc_pend <= 1'b1;
            done     <= !it_last;
            if (it_last) begin
              state <= S_COMMIT;
            end else begin
              state <= S_IDLE;
            end
          end else if (byte_full) begin
            // overrun of the read pointer or of the length byte: roll back
            push_open <= 1'b0;
            kept      <= '0;
            esc_pend  <= 1'b0;
            status    <= ST_NO_SPACE;
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            sp       <= sp_next1;
            esc_pend <= 1'b0;
            if (seg_start_in(sp_next1, rp)) begin
              push_open <= 1'b0;
              kept      <= '0;
              status    <= ST_COLLISION;
              done      <= 1'b1;
              state     <= S_IDLE;
            end else begin
              kept <= kept + 8'd1;
              done <= !it_last;
              if (it_last) begin
                state <= S_COMMIT;
              end else begin
                state <= S_IDLE;
              end
            end
          end
        end

        S_COMMIT: begin
          // length slot goes in this cycle, then the message becomes visible
          wp        <= sp;
          push_open <= 1'b0;
          kept      <= '0;
          esc_pend  <= 1'b0;
          done      <= 1'b1;
          state     <= S_IDLE;
        end

        S_PLEN: begin
          if (ram_rdata == '0) begin
            // zero length marker empties the queue and kills an open push
            rp <= '0;
            wp <= '0;
            if (push_open) begin
              push_open <= 1'b0;
              kept      <= '0;
              esc_pend  <= 1'b0;
            end
            status <= ST_CLEARED;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            rp            <= rp_next1;
            popped_length <= ram_rdata;
            if (rp_next1 == wp) begin
              pop_rem     <= '0;
              message_end <= 1'b1;
              status      <= ST_EMPTY;
              done        <= 1'b1;
              state       <= S_IDLE;
            end else begin
              pop_rem <= ram_rdata;
              done    <= 1'b0;
              state   <= S_PDATA;
            end
          end
        end

        S_PDATA: begin
          data_out   <= ram_rdata;
          byte_valid <= 1'b1;
          rp         <= rp_next1;
          if (rp_next1 == wp) begin
            // caught up with the writer: message cut short
            pop_rem     <= '0;
            message_end <= 1'b1;
          end else begin
            pop_rem     <= pop_rem - 8'd1;
            message_end <= (pop_rem == 8'd1);
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end

        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/lprq_ram.sv
module lprq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/lprq_checker.sv
`include "length_prefixed_ring_message_queue_unit_assert.svh"

module lprq_checker
  import lprq_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic                byte_valid,
  input logic                message_end
);

  `LPRQ_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (!busy && !done), "not idle after reset")
  `LPRQ_ASSERT(a_done_idle, clk, rst, done |-> !busy, "result strobe while busy")
  `LPRQ_ASSERT(a_done_cause, clk, rst, done |-> ($past(busy) || $past(start)), "result with no item")
  `LPRQ_ASSERT(a_byte_ok, clk, rst, (done && byte_valid) |-> (status == ST_OK), "byte with bad status")
  `LPRQ_ASSERT(a_end_empty, clk, rst, (done && message_end && !byte_valid) |-> (status == ST_EMPTY), "early end not empty")

endmodule

bind length_prefixed_ring_message_queue_unit lprq_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .byte_valid  (byte_valid),
  .message_end (message_end)
);
